/* hw/rtl/midi_running_status_event_parser_defines.svh */
// Assertion helpers for the RTL file that carries checks.
// Both expect a clock named clk_i and an active-low reset named rst_ni.
`ifndef MIDI_RUNNING_STATUS_EVENT_PARSER_DEFINES_SVH
`define MIDI_RUNNING_STATUS_EVENT_PARSER_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define MRSEP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define MRSEP_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* hw/rtl/mrsep_pkg.sv */
package mrsep_pkg;

  // Kinds of result produced by the parser.
  typedef enum logic [1:0] {
    EV_CLOCK       = 2'd0,
    EV_START       = 2'd1,
    EV_NOTE_ON     = 2'd2,
    EV_PROG_CHANGE = 2'd3
  } event_kind_e;

  // Request operation codes.
  localparam logic OP_WAIT = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  // System real-time bytes that produce a result.
  localparam logic [7:0] STATUS_CLOCK = 8'hF8;
  localparam logic [7:0] STATUS_START = 8'hFA;

  // Upper nibbles of status bytes.
  localparam logic [3:0] NIB_NOTE_OFF   = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON    = 4'h9;
  localparam logic [3:0] NIB_POLY_PRESS = 4'hA;
  localparam logic [3:0] NIB_CTRL       = 4'hB;
  localparam logic [3:0] NIB_PROG       = 4'hC;
  localparam logic [3:0] NIB_CHAN_PRESS = 4'hD;
  localparam logic [3:0] NIB_PITCH      = 4'hE;
  localparam logic [3:0] NIB_SYSTEM     = 4'hF;

  localparam int unsigned SampleRateWidth = 18;
  localparam logic [SampleRateWidth-1:0] SAMPLE_RATE_RESET = 18'd44100;

  // Wait times are in hundredths of a second.
  localparam logic [6:0] TICKS_PER_SEC = 7'd100;

  // floor(x / 100) = (x * RECIP) >> SHIFT, exact for 24-bit and 25-bit x.
  localparam logic [24:0] RECIP_WAIT = 25'd21474837;
  localparam int unsigned ShiftWait  = 31;
  localparam logic [25:0] RECIP_REM  = 26'd42949673;
  localparam int unsigned ShiftRem   = 32;

  // One parsed event as it travels down the pipeline.
  typedef struct packed {
    logic        fire;
    event_kind_e kind;
    logic [3:0]  chan;
    logic [6:0]  value;
    logic [6:0]  vel;
  } mrsep_evt_t;

  // Stage advance strobes for the timestamp datapath.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } mrsep_adv_t;

  // Number of data bytes that follow a channel status byte.
  function automatic logic [1:0] msg_length(logic [7:0] status);
    logic [1:0] len;
    len = 2'd0;
    unique case (status[7:4]) inside
      NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_PRESS, NIB_CTRL, NIB_PITCH: len = 2'd2;
      NIB_PROG, NIB_CHAN_PRESS: len = 2'd1;
      default: len = 2'd0;
    endcase
    return len;
  endfunction

endpackage

/* hw/rtl/mrsep_byte_parser.sv */
module mrsep_byte_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  logic [7:0]           midi_byte_i,
  output mrsep_pkg::mrsep_evt_t evt_o
);
  import mrsep_pkg::*;

  logic [7:0] status_q, status_d;
  logic [1:0] remain_q, remain_d;
  logic       pos_q, pos_d;
  logic [6:0] data_q [2];
  logic [6:0] data_d [2];
  logic [1:0] run_len;
  logic       fire_msg;

  assign run_len = msg_length(status_q);

  always_comb begin
    status_d = status_q;
    remain_d = remain_q;
    pos_d    = pos_q;
    data_d   = data_q;
    fire_msg = 1'b0;
    evt_o    = '0;
    if (take_i) begin
      if (midi_byte_i[7:4] == NIB_SYSTEM) begin
        // System bytes leave the message state alone.
        if (midi_byte_i == STATUS_CLOCK) begin
          evt_o.fire = 1'b1;
          evt_o.kind = EV_CLOCK;
        end else if (midi_byte_i == STATUS_START) begin
          evt_o.fire = 1'b1;
          evt_o.kind = EV_START;
        end
      end else if (midi_byte_i[7]) begin
        status_d = midi_byte_i;
        remain_d = msg_length(midi_byte_i);
        pos_d    = 1'b0;
      end else if (remain_q != 2'd0) begin
        data_d[pos_q] = midi_byte_i[6:0];
        pos_d         = ~pos_q;
        remain_d      = remain_q - 2'd1;
        fire_msg      = (remain_q == 2'd1);
      end else if (run_len != 2'd0) begin
        // Running status; a cleared status has zero length and drops the byte.
        data_d[0] = midi_byte_i[6:0];
        pos_d     = 1'b1;
        remain_d  = run_len - 2'd1;
        fire_msg  = (run_len == 2'd1);
      end
      if (fire_msg) begin
        case (status_q[7:4])
          NIB_NOTE_ON: begin
            evt_o.fire  = 1'b1;
            evt_o.kind  = EV_NOTE_ON;
            evt_o.chan  = status_q[3:0];
            evt_o.value = data_d[0];
            evt_o.vel   = data_d[1];
          end
          NIB_PROG: begin
            evt_o.fire  = 1'b1;
            evt_o.kind  = EV_PROG_CHANGE;
            evt_o.chan  = status_q[3:0];
            evt_o.value = data_d[0];
          end
          default: evt_o.fire = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= '0;
      remain_q <= '0;
      pos_q    <= 1'b0;
    end else begin
      status_q <= status_d;
      remain_q <= remain_d;
      pos_q    <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

/* hw/rtl/mrsep_time_scale.sv */
module mrsep_time_scale #(
  parameter int unsigned TS_W = 32
) (
  input  logic                                  clk_i,
  input  mrsep_pkg::mrsep_adv_t                 adv_i,
  input  logic [23:0]                           wait_time_i,
  input  logic [mrsep_pkg::SampleRateWidth-1:0] sample_rate_i,
  output logic [TS_W-1:0]                       scaled_o
);
  import mrsep_pkg::*;

  // wait_time = 100*q + r, so wait_time*rate/100 = q*rate + floor(r*rate/100).
  logic [48:0] wait_prod;
  logic [17:0] quot_c;
  logic [23:0] rem_full;
  logic [17:0] quot_q;
  logic [6:0]  rem_q;
  logic [35:0] p1_c, p1_q, p1_s3_q;
  logic [24:0] p2_c, p2_q;
  logic [50:0] rem_prod;
  logic [17:0] frac_c, frac_q;

  assign wait_prod = 49'(wait_time_i) * 49'(RECIP_WAIT);
  assign quot_c    = wait_prod[ShiftWait+17:ShiftWait];
  assign rem_full  = wait_time_i - 24'(24'(quot_c) * 24'(TICKS_PER_SEC));

  assign p1_c = 36'(quot_q) * 36'(sample_rate_i);
  assign p2_c = 25'(rem_q) * 25'(sample_rate_i);

  assign rem_prod = 51'(p2_q) * 51'(RECIP_REM);
  assign frac_c   = rem_prod[ShiftRem+17:ShiftRem];

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      quot_q <= quot_c;
      rem_q  <= rem_full[6:0];
    end
    if (adv_i.s2) begin
      p1_q <= p1_c;
      p2_q <= p2_c;
    end
    if (adv_i.s3) begin
      p1_s3_q <= p1_q;
      frac_q  <= frac_c;
    end
  end

  assign scaled_o = TS_W'(37'(p1_s3_q) + 37'(frac_q));

endmodule

/* hw/rtl/midi_running_status_event_parser.sv */
// Channel   Direction  Handshake              Payload
// request   in         in_valid_i/in_stall_o  operation, wait_time, midi_byte, now_sample_time
// result    out        out_valid_o/out_stall_i event_kind, channel, note_or_program, velocity,
//                                              timestamp
// config    in         cfg_we_i               cfg_wdata_i (sample rate)
//
// One request is taken every cycle unless in_stall_o is high. A request passes through
// stages 1 to 3, an event then the result register; the stages come from the divide by
// 100 of the timestamp path: quotient, rate and remainder multiply, one register each.
// Reset is asynchronous and active low; it clears the parser, the offset and the timestamp.
// A stalled result is held while empty pipeline stages keep filling behind it.
`include "midi_running_status_event_parser_defines.svh"

module midi_running_status_event_parser #(
  parameter int unsigned TIMESTAMP_WIDTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [mrsep_pkg::SampleRateWidth-1:0] cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  operation_i,
  input  logic [23:0]                           wait_time_i,
  input  logic [7:0]                            midi_byte_i,
  input  logic [31:0]                           now_sample_time_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [1:0]                            event_kind_o,
  output logic [3:0]                            channel_o,
  output logic [6:0]                            note_or_program_o,
  output logic [6:0]                            velocity_o,
  output logic [31:0]                           timestamp_o
);
  import mrsep_pkg::*;

  // Only the low 32 timestamp bits ever reach the port, and modular arithmetic lets
  // every operand be cut to that many bits.
  localparam int unsigned TsKeep = (TIMESTAMP_WIDTH < 32) ? TIMESTAMP_WIDTH : 32;

  logic [SampleRateWidth-1:0] sample_rate_q;

  // Requests move through three stages in order; events then enter the result register.
  // Byte requests are parsed on entry and carry their event along; wait requests pick up
  // their scaled time on the way and update the timestamp state when they leave stage 3.
  // Byte requests that produce nothing are dropped on entry.
  logic              s1_v_q, s2_v_q, s3_v_q, out_valid_q;
  logic              s1_wait_q, s2_wait_q, s3_wait_q;
  mrsep_evt_t        s1_evt_q, s2_evt_q, s3_evt_q;
  logic [TsKeep-1:0] s1_now_q, s2_now_q, s3_now_q;

  logic       en1, en2, en3, en_out;
  logic       accept, take_byte, is_wait;
  mrsep_evt_t evt_c;
  mrsep_adv_t adv;
  logic [TsKeep-1:0] scaled;

  // Timestamp state. The two offsets of the first wait are kept as their difference,
  // sample time minus scaled time, so a later wait needs one addition.
  logic              offset_valid_q, offset_valid_d;
  logic [TsKeep-1:0] delta_q, delta_d;
  logic [TsKeep-1:0] last_ts_q, last_ts_d;
  logic              wait_done;

  logic [1:0]  event_kind_q;
  logic [3:0]  channel_q;
  logic [6:0]  value_q;
  logic [6:0]  velocity_q;
  logic [TsKeep-1:0] ts_out_q;

  // A stage moves when it is empty or the stage after it moves.
  assign en_out = !out_valid_q || !out_stall_i;
  assign en3    = !s3_v_q || en_out;
  assign en2    = !s2_v_q || en3;
  assign en1    = !s1_v_q || en2;

  assign in_stall_o = !en1;
  assign accept     = in_valid_i && en1;
  assign is_wait    = (operation_i == OP_WAIT);
  assign take_byte  = accept && (operation_i == OP_BYTE);

  assign adv.s1 = en1;
  assign adv.s2 = en2;
  assign adv.s3 = en3;

  mrsep_byte_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take_byte),
    .midi_byte_i (midi_byte_i),
    .evt_o       (evt_c)
  );

  mrsep_time_scale #(
    .TS_W (TsKeep)
  ) u_time_scale (
    .clk_i         (clk_i),
    .adv_i         (adv),
    .wait_time_i   (wait_time_i),
    .sample_rate_i (sample_rate_q),
    .scaled_o      (scaled)
  );

  // The first wait fixes the offset, which makes its own timestamp the sample time.
  assign wait_done = en_out && s3_v_q && s3_wait_q;

  always_comb begin
    offset_valid_d = offset_valid_q;
    delta_d        = delta_q;
    last_ts_d      = last_ts_q;
    if (wait_done) begin
      if (!offset_valid_q) begin
        offset_valid_d = 1'b1;
        delta_d        = s3_now_q - scaled;
        last_ts_d      = s3_now_q;
      end else begin
        last_ts_d = scaled + delta_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_rate_q  <= SAMPLE_RATE_RESET;
      s1_v_q         <= 1'b0;
      s2_v_q         <= 1'b0;
      s3_v_q         <= 1'b0;
      out_valid_q    <= 1'b0;
      offset_valid_q <= 1'b0;
      delta_q        <= '0;
      last_ts_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        sample_rate_q <= cfg_wdata_i;
      end
      if (en1) begin
        s1_v_q <= accept && (is_wait || evt_c.fire);
      end
      if (en2) begin
        s2_v_q <= s1_v_q;
      end
      if (en3) begin
        s3_v_q <= s2_v_q;
      end
      if (en_out) begin
        out_valid_q <= s3_v_q && !s3_wait_q;
      end
      offset_valid_q <= offset_valid_d;
      delta_q        <= delta_d;
      last_ts_q      <= last_ts_d;
    end
  end

  // Payload registers follow their stage's advance and need no reset.
  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_wait_q <= is_wait;
      s1_evt_q  <= evt_c;
      s1_now_q  <= now_sample_time_i[TsKeep-1:0];
    end
    if (en2) begin
      s2_wait_q <= s1_wait_q;
      s2_evt_q  <= s1_evt_q;
      s2_now_q  <= s1_now_q;
    end
    if (en3) begin
      s3_wait_q <= s2_wait_q;
      s3_evt_q  <= s2_evt_q;
      s3_now_q  <= s2_now_q;
    end
    if (en_out) begin
      // Waits ahead of this event have already updated the timestamp.
      event_kind_q <= s3_evt_q.kind;
      channel_q    <= s3_evt_q.chan;
      value_q      <= s3_evt_q.value;
      velocity_q   <= s3_evt_q.vel;
      ts_out_q     <= last_ts_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign event_kind_o      = event_kind_q;
  assign channel_o         = channel_q;
  assign note_or_program_o = value_q;
  assign velocity_o        = velocity_q;
  assign timestamp_o       = 32'(ts_out_q);

  `MRSEP_ASSERT(a_stall_only_when_full, in_stall_o |-> (s1_v_q && s2_v_q && s3_v_q && out_valid_q && out_stall_i), "input stalled with a free pipeline stage")
  `MRSEP_ASSERT(a_first_wait_takes_now, (wait_done && !offset_valid_q) |=> (offset_valid_q && last_ts_q == $past(s3_now_q)), "first wait did not fix the offset")
  `MRSEP_ASSERT(a_system_fields_zero, (out_valid_q && (event_kind_q == EV_CLOCK || event_kind_q == EV_START)) |-> (channel_q == 4'd0 && value_q == 7'd0 && velocity_q == 7'd0), "clock or start event carries data")
  `MRSEP_NEVER(a_wait_never_results, en_out && s3_v_q && s3_wait_q && s3_evt_q.fire, "wait request carries an event")

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

// Testbench for the MIDI running-status event parser.
//
// Requests (wait items and MIDI byte items) are sent one at a time through
// send_request. When a request is accepted, the parser state that this bench
// keeps is advanced. Any event the request should produce is queued in
// pending_events. A checker process compares each accepted result against the
// oldest queued event, field by field.
module tb_top;
  import mrsep_pkg::*;

  // A cycle count with no accepted request and no accepted result that ends the run.
  // A receiver stall run is bounded by stall_hold, but several can follow one another,
  // so a quiet stretch well beyond one stall run is possible but rare.
  localparam int QuietLimit = 1000;
  // Cycles to let a wait request leave the three-stage timestamp pipeline.
  localparam int SettleCycles = 8;
  localparam int MaxReported = 10;

  typedef struct packed {
    event_kind_e kind;
    logic [3:0]  chan;
    logic [6:0]  value;
    logic [6:0]  vel;
    logic [31:0] stamp;
  } midi_event_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [SampleRateWidth-1:0] cfg_wdata_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic                       operation_i = OP_WAIT;
  logic [23:0]                wait_time_i = '0;
  logic [7:0]                 midi_byte_i = '0;
  logic [31:0]                now_sample_time_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [1:0]                 event_kind_o;
  logic [3:0]                 channel_o;
  logic [6:0]                 note_or_program_o;
  logic [6:0]                 velocity_o;
  logic [31:0]                timestamp_o;

  // The bench's own copy of the parser state, the timestamp offsets and the register.
  logic [SampleRateWidth-1:0] sample_rate_q;
  logic [7:0]                 run_status;
  logic [1:0]                 bytes_left;
  logic [6:0]                 data_byte [2];
  logic                       data_pos;
  logic                       offset_locked;
  logic [47:0]                midi_offset;
  logic [31:0]                sample_offset;
  logic [31:0]                last_stamp;

  midi_event_t pending_events [$];

  int error_count = 0;
  int sent_count = 0;
  int quiet_cycles = 0;
  int stall_hold = 0;
  // Idling modes: 0 never idles, 1 idles lightly, 2 idles heavily.
  int sender_idle_mode = 0;
  int receiver_idle_mode = 0;

  midi_running_status_event_parser i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .operation_i       (operation_i),
    .wait_time_i       (wait_time_i),
    .midi_byte_i       (midi_byte_i),
    .now_sample_time_i (now_sample_time_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .event_kind_o      (event_kind_o),
    .channel_o         (channel_o),
    .note_or_program_o (note_or_program_o),
    .velocity_o        (velocity_o),
    .timestamp_o       (timestamp_o)
  );

  always #4 clk_i = ~clk_i;

  // Number of data bytes that follow a channel status byte.
  function automatic logic [1:0] status_len(input logic [7:0] status);
    case (status[7:4])
      NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_PRESS, NIB_CTRL, NIB_PITCH: return 2'd2;
      NIB_PROG, NIB_CHAN_PRESS: return 2'd1;
      default: return 2'd0;
    endcase
  endfunction

  // Queues one event that carries the timestamp of the most recent wait request.
  function automatic void expect_event(input event_kind_e kind, input logic [3:0] chan,
                                       input logic [6:0] value, input logic [6:0] vel);
    midi_event_t ev;
    ev.kind  = kind;
    ev.chan  = chan;
    ev.value = value;
    ev.vel   = vel;
    ev.stamp = last_stamp;
    pending_events.push_back(ev);
  endfunction

  // A completed message produces an event only for note on and program change.
  function automatic void complete_message();
    if (run_status[7:4] == NIB_NOTE_ON) begin
      expect_event(EV_NOTE_ON, run_status[3:0], data_byte[0], data_byte[1]);
    end else if (run_status[7:4] == NIB_PROG) begin
      expect_event(EV_PROG_CHANGE, run_status[3:0], data_byte[0], 7'd0);
    end
  endfunction

  // Advances the parser by one accepted request.
  function automatic void parse_request(input logic op, input logic [23:0] wt,
                                        input logic [7:0] b, input logic [31:0] now);
    logic [63:0] wide_time;
    logic [63:0] wide_rate;
    logic [63:0] scaled;
    logic [63:0] stamp;
    logic [1:0]  len;
    if (op == OP_WAIT) begin
      // Hundredths of a second become samples. The first wait fixes both offsets,
      // and every later difference wraps at 32 bits.
      wide_time = wt;
      wide_rate = sample_rate_q;
      scaled = wide_time * wide_rate / TICKS_PER_SEC;
      if (!offset_locked) begin
        midi_offset   = scaled[47:0];
        sample_offset = now;
        offset_locked = 1'b1;
      end
      stamp = scaled - {16'd0, midi_offset} + {32'd0, sample_offset};
      last_stamp = stamp[31:0];
      return;
    end
    // System bytes never touch the parser state; only clock and start report.
    if (b[7:4] == NIB_SYSTEM) begin
      if (b == STATUS_CLOCK) begin
        expect_event(EV_CLOCK, 4'd0, 7'd0, 7'd0);
      end else if (b == STATUS_START) begin
        expect_event(EV_START, 4'd0, 7'd0, 7'd0);
      end
      return;
    end
    if (b[7]) begin
      run_status = b;
      bytes_left = status_len(b);
      data_pos   = 1'b0;
      return;
    end
    if (bytes_left != 2'd0) begin
      data_byte[data_pos] = b[6:0];
      data_pos   = ~data_pos;
      bytes_left = bytes_left - 2'd1;
      if (bytes_left == 2'd0) complete_message();
      return;
    end
    // A data byte with no status seen yet is dropped.
    if (run_status == 8'd0) return;
    // Under running status the data byte opens a new message, and a
    // one-byte message completes right away.
    len = status_len(run_status);
    if (len == 2'd0) return;
    data_byte[0] = b[6:0];
    data_pos     = 1'b1;
    bytes_left   = len - 2'd1;
    if (bytes_left == 2'd0) complete_message();
  endfunction

  // Most requests follow with no gap or a short one; now and then a long one.
  function automatic int pick_gap(input int mode);
    if (mode == 0 || $urandom_range(99) < (mode == 1 ? 70 : 40)) return 0;
    if ($urandom_range(15) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic void note_failure(input string msg);
    error_count++;
    if (error_count <= MaxReported) $display("ERROR: %s", msg);
  endfunction

  // Sends one request, holding it steady until the parser takes it.
  task automatic send_request(input logic op, input logic [23:0] wt, input logic [7:0] b,
                              input logic [31:0] now);
    int gap;
    gap = pick_gap(sender_idle_mode);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    operation_i       <= op;
    wait_time_i       <= wt;
    midi_byte_i       <= b;
    now_sample_time_i <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    parse_request(op, wt, b, now);
    sent_count++;
  endtask

  // Byte and wait requests still carry random values in their unused fields.
  task automatic send_byte(input logic [7:0] b);
    send_request(OP_BYTE, 24'($urandom), b, $urandom);
  endtask

  task automatic send_wait(input logic [23:0] wt, input logic [31:0] now);
    send_request(OP_WAIT, wt, 8'($urandom), now);
  endtask

  // Stops sending and waits until every queued event has come out. Wait requests
  // produce nothing, so a further SettleCycles wait lets the timestamp pipeline empty.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_sample_rate(input logic [SampleRateWidth-1:0] rate);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= rate;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    sample_rate_q = rate;
  endtask

  // One random request or one short sequence. Most of the traffic is well-formed
  // channel messages with random content. Some use running status, some are cut
  // short, and some have real-time bytes between their data bytes. The rest is
  // wait requests, system bytes and noise.
  task automatic send_random_item();
    int          pick;
    logic [7:0]  status;
    logic [1:0]  len;
    int          i;
    pick = $urandom_range(99);
    if (pick < 15) begin
      send_wait(24'($urandom), $urandom);
    end else if (pick < 25) begin
      case ($urandom_range(2))
        0: send_byte(STATUS_CLOCK);
        1: send_byte(STATUS_START);
        default: send_byte({NIB_SYSTEM, 4'($urandom)});
      endcase
    end else if (pick < 80) begin
      if (run_status != 8'd0 && $urandom_range(2) == 0) begin
        status = run_status;
      end else begin
        pick = $urandom_range(99);
        if (pick < 40) status = {NIB_NOTE_ON, 4'($urandom)};
        else if (pick < 70) status = {NIB_PROG, 4'($urandom)};
        else status = {4'($urandom_range(8, 14)), 4'($urandom)};
        send_byte(status);
      end
      len = status_len(status);
      for (i = 0; i < len; i++) begin
        if ($urandom_range(19) == 0) send_byte(STATUS_CLOCK);
        if ($urandom_range(39) == 0) break;
        send_byte({1'b0, 7'($urandom)});
      end
    end else begin
      send_byte(8'($urandom));
    end
  endtask

  task automatic run_random_items(input int count);
    int start;
    start = sent_count;
    while (sent_count - start < count) send_random_item();
  endtask

  // Reset value of the sample rate, parsing before any status, the first wait
  // fixing the offsets, running status for two-byte and one-byte messages, note
  // on with velocity zero, messages that produce nothing, system bytes inside a
  // message, and a wait earlier than the first.
  task automatic test_directed_parsing();
    sender_idle_mode   = 0;
    receiver_idle_mode = 0;
    send_byte(8'h45);
    send_byte(STATUS_CLOCK);
    send_wait(24'h400000, 32'hFFFF_FFF0);
    send_byte(STATUS_START);
    send_byte(8'h9F);
    send_byte(8'h7F);
    send_byte(8'h7F);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hC3);
    send_byte(8'hF0);
    send_byte(8'h7F);
    send_byte(8'h05);
    send_byte(8'h80);
    send_byte(8'h10);
    send_byte(8'h20);
    send_byte(8'hD1);
    send_byte(8'h22);
    send_wait(24'h000000, 32'h0000_0000);
    send_byte(STATUS_CLOCK);
    send_wait(24'hFFFFFF, 32'hFFFF_FFFF);
    send_byte(8'hFF);
    send_byte(STATUS_CLOCK);
  endtask

  task automatic test_traffic_without_idling();
    sender_idle_mode   = 0;
    receiver_idle_mode = 0;
    run_random_items(250);
  endtask

  task automatic test_slowest_sample_rate();
    write_sample_rate(18'd1);
    sender_idle_mode   = 1;
    receiver_idle_mode = 1;
    run_random_items(300);
  endtask

  task automatic test_fastest_sample_rate();
    write_sample_rate(18'd192000);
    sender_idle_mode   = 2;
    receiver_idle_mode = 2;
    run_random_items(300);
  endtask

  // With a zero rate, every scaled time is zero, and only the offsets remain.
  task automatic test_zero_sample_rate();
    write_sample_rate(18'd0);
    sender_idle_mode   = 1;
    receiver_idle_mode = 2;
    run_random_items(150);
  endtask

  task automatic test_random_sample_rates();
    int phase;
    for (phase = 0; phase < 3; phase++) begin
      write_sample_rate(18'($urandom_range(1, 192000)));
      sender_idle_mode   = $urandom_range(2);
      receiver_idle_mode = $urandom_range(2);
      run_random_items(250);
    end
  endtask

  // Receiver back-pressure: runs of stall or no stall, mostly short, a few long.
  always @(posedge clk_i) begin
    if (stall_hold != 0) begin
      stall_hold--;
    end else begin
      out_stall_i <= (receiver_idle_mode != 0) &&
                     ($urandom_range(99) < (receiver_idle_mode == 1 ? 20 : 45));
      stall_hold = ($urandom_range(15) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
    end
  end

  // Every accepted result must match the oldest queued event.
  always @(posedge clk_i) begin : check_result
    midi_event_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_events.size() == 0) begin
        note_failure($sformatf("unexpected result kind=%0d ch=%0d val=%0d vel=%0d ts=%h",
                               event_kind_o, channel_o, note_or_program_o, velocity_o,
                               timestamp_o));
      end else begin
        want = pending_events.pop_front();
        if (want.kind !== event_kind_o || want.chan !== channel_o ||
            want.value !== note_or_program_o || want.vel !== velocity_o ||
            want.stamp !== timestamp_o) begin
          note_failure($sformatf(
            "expected kind=%0d ch=%0d val=%0d vel=%0d ts=%h, got %0d %0d %0d %0d %h",
            want.kind, want.chan, want.value, want.vel, want.stamp, event_kind_o,
            channel_o, note_or_program_o, velocity_o, timestamp_o));
        end
      end
    end
  end

  // The run is ended if neither channel moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    sample_rate_q = SAMPLE_RATE_RESET;
    run_status    = 8'd0;
    bytes_left    = 2'd0;
    data_byte[0]  = 7'd0;
    data_byte[1]  = 7'd0;
    data_pos      = 1'b0;
    offset_locked = 1'b0;
    midi_offset   = '0;
    sample_offset = '0;
    last_stamp    = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_parsing();
    test_traffic_without_idling();
    test_slowest_sample_rate();
    test_fastest_sample_rate();
    test_zero_sample_rate();
    test_random_sample_rates();

    drain_results();
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
